### sv/psf2_pkg.sv
package psf2_pkg;

  localparam int unsigned GLYPH_COUNT_BITS_DEF = 16;
  localparam int unsigned GLYPH_SIZE_BITS_DEF  = 12;

  localparam logic [31:0] PSF2_MAGIC   = 32'h864a_b572;
  localparam logic [31:0] HEADER_BYTES = 32'd32;
  localparam logic [7:0]  GLYPH_SEP    = 8'hFF;
  localparam logic [7:0]  LEAD_1_MAX   = 8'h7F;
  localparam logic [7:0]  LEAD_2_MAX   = 8'hDF;
  localparam logic [7:0]  LEAD_3_MAX   = 8'hEF;

  localparam logic [4:0]  HDR_LAST     = 5'd31;

  // header word numbers
  localparam logic [2:0]  HW_MAGIC  = 3'd0;
  localparam logic [2:0]  HW_HSIZE  = 3'd2;
  localparam logic [2:0]  HW_COUNT  = 3'd4;
  localparam logic [2:0]  HW_SIZE   = 3'd5;
  localparam logic [2:0]  HW_HEIGHT = 3'd6;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_GLYPHS = 2'd1,
    PH_TABLE  = 2'd2,
    PH_IDLE   = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    KIND_HDR_OK   = 3'd0,
    KIND_HDR_BAD  = 3'd1,
    KIND_GLYPH    = 3'd2,
    KIND_MAP      = 3'd3,
    KIND_TBL_DONE = 3'd4
  } kind_t;

  function automatic logic [15:0] sat16(input logic [31:0] v);
    logic [15:0] r;
    r = (v[31:16] != 16'd0) ? 16'hFFFF : v[15:0];
    return r;
  endfunction

endpackage

### sv/psf2_font_stream_parser.sv
// PSF2 font stream parser. Takes one font file byte per clock (in_file_start
// marks byte 0 of a new file and restarts the parse), checks the 32-byte
// header, then reports every glyph bitmap byte and every Unicode table key
// with its glyph number. A byte can be accepted every cycle; a byte waits in
// the input register only while a finished word is held on the output. Each
// byte passes an input register and a result register, so its word, if any,
// is loaded as the byte leaves the input register. Bytes that produce nothing
// (most header bytes, inner key bytes, line ends, anything after the table or
// a rejected header) leave no word on the output. Glyph count and glyph size
// wider than GLYPH_COUNT_BITS / GLYPH_SIZE_BITS make the header rejected.
module psf2_font_stream_parser #(
  parameter int unsigned GLYPH_COUNT_BITS = psf2_pkg::GLYPH_COUNT_BITS_DEF,
  parameter int unsigned GLYPH_SIZE_BITS  = psf2_pkg::GLYPH_SIZE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_file_byte,
  input  logic        in_file_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [15:0] out_glyph_index,
  output logic [11:0] out_byte_index,
  output logic [7:0]  out_data_byte,
  output logic [31:0] out_char_key,
  output logic [15:0] out_glyph_total,
  output logic [11:0] out_glyph_bytes,
  output logic [15:0] out_glyph_height,
  output logic [15:0] out_glyph_width
);

  localparam int unsigned GCB = GLYPH_COUNT_BITS;
  localparam int unsigned GSB = GLYPH_SIZE_BITS;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_start_r;
  logic       s1_adv;

  // parse state
  psf2_pkg::phase_t phase_r, phase_nxt;
  logic [4:0]     hcount_r, hcount_nxt;
  logic [31:0]    wshift_r, wshift_nxt;
  logic           hok_r, hok_nxt;
  logic [GCB-1:0] total_r, total_nxt;
  logic [GSB-1:0] bpg_r, bpg_nxt;
  logic [15:0]    height_r, height_nxt;
  logic [GCB-1:0] gcnt_r, gcnt_nxt;
  logic [GSB-1:0] bcnt_r, bcnt_nxt;
  logic [1:0]     bleft_r, bleft_nxt;
  logic [31:0]    key_r, key_nxt;

  // state as seen by the current byte (restart applied)
  psf2_pkg::phase_t cur_phase;
  logic [4:0]     cur_hcount;
  logic [31:0]    cur_wshift;
  logic           cur_hok;
  logic [GCB-1:0] cur_total;
  logic [GSB-1:0] cur_bpg;
  logic [15:0]    cur_height;
  logic [GCB-1:0] cur_gcnt;
  logic [GSB-1:0] cur_bcnt;
  logic [1:0]     cur_bleft;
  logic [31:0]    cur_key;

  logic [31:0]    ws_new;
  logic           word_done;
  logic           hdr_last;
  logic [GSB-1:0] bcnt_inc;
  logic [GCB-1:0] gcnt_inc;
  logic           glyph_end;
  logic           count_end;
  logic [31:0]    key_shift;

  // result
  logic        res_valid;
  psf2_pkg::kind_t res_kind;
  logic [15:0] res_gindex;
  logic [11:0] res_bindex;
  logic [7:0]  res_data;
  logic [31:0] res_key;
  logic [15:0] res_gtotal;
  logic [11:0] res_gbytes;
  logic [15:0] res_height;
  logic [15:0] res_width;

  logic        out_valid_r;
  logic [2:0]  out_kind_r;
  logic [15:0] out_gindex_r;
  logic [11:0] out_bindex_r;
  logic [7:0]  out_data_r;
  logic [31:0] out_key_r;
  logic [15:0] out_gtotal_r;
  logic [11:0] out_gbytes_r;
  logic [15:0] out_height_r;
  logic [15:0] out_width_r;

  logic [31:0] gcnt_ext, bcnt_ext, total_ext, bpg_ext;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r  <= in_file_byte;
      s1_start_r <= in_file_start;
    end
  end

  always_comb begin
    if (s1_start_r) begin
      cur_phase  = psf2_pkg::PH_HEADER;
      cur_hcount = '0;
      cur_wshift = '0;
      cur_hok    = 1'b1;
      cur_total  = '0;
      cur_bpg    = '0;
      cur_height = '0;
      cur_gcnt   = '0;
      cur_bcnt   = '0;
      cur_bleft  = '0;
      cur_key    = '0;
    end else begin
      cur_phase  = phase_r;
      cur_hcount = hcount_r;
      cur_wshift = wshift_r;
      cur_hok    = hok_r;
      cur_total  = total_r;
      cur_bpg    = bpg_r;
      cur_height = height_r;
      cur_gcnt   = gcnt_r;
      cur_bcnt   = bcnt_r;
      cur_bleft  = bleft_r;
      cur_key    = key_r;
    end
  end

  assign ws_new    = {s1_byte_r, cur_wshift[31:8]};
  assign word_done = (cur_hcount[1:0] == 2'b11);
  assign hdr_last  = (cur_hcount == psf2_pkg::HDR_LAST);
  assign bcnt_inc  = cur_bcnt + GSB'(1);
  assign gcnt_inc  = cur_gcnt + GCB'(1);
  assign glyph_end = (bcnt_inc >= cur_bpg);
  assign count_end = (gcnt_inc >= cur_total);
  assign key_shift = {cur_key[23:0], s1_byte_r};

  // next state
  always_comb begin
    phase_nxt  = cur_phase;
    hcount_nxt = cur_hcount;
    wshift_nxt = cur_wshift;
    hok_nxt    = cur_hok;
    total_nxt  = cur_total;
    bpg_nxt    = cur_bpg;
    height_nxt = cur_height;
    gcnt_nxt   = cur_gcnt;
    bcnt_nxt   = cur_bcnt;
    bleft_nxt  = cur_bleft;
    key_nxt    = cur_key;
    case (cur_phase)
      psf2_pkg::PH_HEADER: begin
        wshift_nxt = ws_new;
        hcount_nxt = cur_hcount + 5'd1;
        if (word_done) begin
          case (cur_hcount[4:2])
            psf2_pkg::HW_MAGIC: begin
              if (ws_new != psf2_pkg::PSF2_MAGIC) hok_nxt = 1'b0;
            end
            psf2_pkg::HW_HSIZE: begin
              if (ws_new != psf2_pkg::HEADER_BYTES) hok_nxt = 1'b0;
            end
            psf2_pkg::HW_COUNT: begin
              if ((ws_new >> GCB) != 32'd0) hok_nxt = 1'b0;
              total_nxt = GCB'(ws_new);
            end
            psf2_pkg::HW_SIZE: begin
              if ((ws_new >> GSB) != 32'd0) hok_nxt = 1'b0;
              bpg_nxt = GSB'(ws_new);
            end
            psf2_pkg::HW_HEIGHT: begin
              height_nxt = psf2_pkg::sat16(ws_new);
            end
            default: begin
            end
          endcase
        end
        if (hdr_last) begin
          gcnt_nxt  = '0;
          bcnt_nxt  = '0;
          bleft_nxt = '0;
          key_nxt   = '0;
          if (!cur_hok || cur_total == '0) begin
            phase_nxt = psf2_pkg::PH_IDLE;
          end else if (cur_bpg == '0) begin
            phase_nxt = psf2_pkg::PH_TABLE;
          end else begin
            phase_nxt = psf2_pkg::PH_GLYPHS;
          end
        end
      end
      psf2_pkg::PH_GLYPHS: begin
        bcnt_nxt = bcnt_inc;
        if (glyph_end) begin
          bcnt_nxt = '0;
          gcnt_nxt = gcnt_inc;
          if (count_end) begin
            gcnt_nxt  = '0;
            phase_nxt = psf2_pkg::PH_TABLE;
          end
        end
      end
      psf2_pkg::PH_TABLE: begin
        if (cur_bleft != 2'd0) begin
          key_nxt   = key_shift;
          bleft_nxt = cur_bleft - 2'd1;
        end else if (s1_byte_r == psf2_pkg::GLYPH_SEP) begin
          gcnt_nxt = gcnt_inc;
          if (count_end) phase_nxt = psf2_pkg::PH_IDLE;
        end else begin
          key_nxt = {24'd0, s1_byte_r};
          if (s1_byte_r <= psf2_pkg::LEAD_1_MAX) begin
            bleft_nxt = 2'd0;
          end else if (s1_byte_r <= psf2_pkg::LEAD_2_MAX) begin
            bleft_nxt = 2'd1;
          end else if (s1_byte_r <= psf2_pkg::LEAD_3_MAX) begin
            bleft_nxt = 2'd2;
          end else begin
            bleft_nxt = 2'd3;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign gcnt_ext  = 32'(cur_gcnt);
  assign bcnt_ext  = 32'(cur_bcnt);
  assign total_ext = 32'(cur_total);
  assign bpg_ext   = 32'(cur_bpg);

  // result
  always_comb begin
    res_valid  = 1'b0;
    res_kind   = psf2_pkg::KIND_HDR_OK;
    res_gindex = '0;
    res_bindex = '0;
    res_data   = '0;
    res_key    = '0;
    res_gtotal = '0;
    res_gbytes = '0;
    res_height = '0;
    res_width  = '0;
    case (cur_phase)
      psf2_pkg::PH_HEADER: begin
        if (hdr_last) begin
          res_valid = 1'b1;
          if (!cur_hok) begin
            res_kind = psf2_pkg::KIND_HDR_BAD;
          end else begin
            res_kind   = psf2_pkg::KIND_HDR_OK;
            res_gtotal = total_ext[15:0];
            res_gbytes = bpg_ext[11:0];
            res_height = cur_height;
            res_width  = psf2_pkg::sat16(ws_new);
          end
        end
      end
      psf2_pkg::PH_GLYPHS: begin
        res_valid  = 1'b1;
        res_kind   = psf2_pkg::KIND_GLYPH;
        res_gindex = gcnt_ext[15:0];
        res_bindex = bcnt_ext[11:0];
        res_data   = s1_byte_r;
      end
      psf2_pkg::PH_TABLE: begin
        if (cur_bleft != 2'd0) begin
          if (cur_bleft == 2'd1) begin
            res_valid  = 1'b1;
            res_kind   = psf2_pkg::KIND_MAP;
            res_gindex = gcnt_ext[15:0];
            res_key    = key_shift;
          end
        end else if (s1_byte_r == psf2_pkg::GLYPH_SEP) begin
          if (count_end) begin
            res_valid = 1'b1;
            res_kind  = psf2_pkg::KIND_TBL_DONE;
          end
        end else if (s1_byte_r <= psf2_pkg::LEAD_1_MAX) begin
          res_valid  = 1'b1;
          res_kind   = psf2_pkg::KIND_MAP;
          res_gindex = gcnt_ext[15:0];
          res_key    = {24'd0, s1_byte_r};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= psf2_pkg::PH_HEADER;
      hcount_r <= '0;
      wshift_r <= '0;
      hok_r    <= 1'b1;
      total_r  <= '0;
      bpg_r    <= '0;
      height_r <= '0;
      gcnt_r   <= '0;
      bcnt_r   <= '0;
      bleft_r  <= '0;
      key_r    <= '0;
    end else if (s1_adv) begin
      phase_r  <= phase_nxt;
      hcount_r <= hcount_nxt;
      wshift_r <= wshift_nxt;
      hok_r    <= hok_nxt;
      total_r  <= total_nxt;
      bpg_r    <= bpg_nxt;
      height_r <= height_nxt;
      gcnt_r   <= gcnt_nxt;
      bcnt_r   <= bcnt_nxt;
      bleft_r  <= bleft_nxt;
      key_r    <= key_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= s1_adv && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res_valid) begin
      out_kind_r   <= res_kind;
      out_gindex_r <= res_gindex;
      out_bindex_r <= res_bindex;
      out_data_r   <= res_data;
      out_key_r    <= res_key;
      out_gtotal_r <= res_gtotal;
      out_gbytes_r <= res_gbytes;
      out_height_r <= res_height;
      out_width_r  <= res_width;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_glyph_index  = out_gindex_r;
  assign out_byte_index   = out_bindex_r;
  assign out_data_byte    = out_data_r;
  assign out_char_key     = out_key_r;
  assign out_glyph_total  = out_gtotal_r;
  assign out_glyph_bytes  = out_gbytes_r;
  assign out_glyph_height = out_height_r;
  assign out_glyph_width  = out_width_r;

  a_idle_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !s1_start_r && phase_r == psf2_pkg::PH_IDLE)
    |=> (phase_r == psf2_pkg::PH_IDLE))
    else $error("left idle phase without a new file");

  a_gcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == psf2_pkg::PH_GLYPHS || phase_r == psf2_pkg::PH_TABLE)
    |-> (gcnt_r < total_r))
    else $error("glyph counter beyond glyph count");

  a_bcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == psf2_pkg::PH_GLYPHS) |-> (bcnt_r < bpg_r))
    else $error("byte counter beyond glyph size");

  a_bleft_table: assert property (@(posedge clk) disable iff (!rst_n)
    (bleft_r != 2'd0) |-> (phase_r == psf2_pkg::PH_TABLE))
    else $error("pending key bytes outside the table");

endmodule
